FILE: src/lwh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Langevin walk histogram package
// Shared widths, register indexes, reset values and controller types.
// ----------------------------------------------------------------------------
package lwh_pkg;

    localparam int MAX_BINS     = 1024;
    localparam int BIN_BITS     = $clog2(MAX_BINS);
    localparam int COUNT_BITS   = 32;
    localparam int POS_BITS     = 17;
    localparam int COEF_BITS    = 16;
    localparam int USED_BITS    = 11;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 17;

    // The distance top_edge - position spans 17 bits, one quotient bit per step.
    localparam int DIV_STEPS    = POS_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam logic signed [POS_BITS+1:0] POS_MAX = 19'sd65535;
    localparam logic signed [POS_BITS+1:0] POS_MIN = -19'sd65536;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOISE     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOP       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USED      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_POS = 3'd5;

    localparam logic [COEF_BITS-1:0] DECAY_RESET = 16'd64880;
    localparam logic [COEF_BITS-1:0] NOISE_RESET = 16'd579;
    localparam logic [COEF_BITS-1:0] TOP_RESET   = 16'd16384;
    localparam logic [COEF_BITS-1:0] WIDTH_RESET = 16'd41;
    localparam logic [USED_BITS-1:0] USED_RESET  = 11'd800;
    localparam logic signed [POS_BITS-1:0] START_POS_RESET = 17'sd0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_BIN,
        S_RD,
        S_INC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;      // latch the accepted input beat
        logic mul;       // register position * decay
        logic add;       // round, add noise, saturate, start divider
        logic div_step;  // one restoring division step
        logic bin;       // decide bin and hit
        logic rd;        // read the histogram entry
        logic inc;       // update the entry and form the count
        logic out_load;  // move the result into the output register
        logic clr_step;  // clear one histogram entry
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;   // latched beat is a bin read
        logic div_last;  // this is the final division step
        logic clr_last;  // this is the final entry of the clearing pass
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: src/lwh_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Langevin walk histogram channels
// Valid/ready channels for the input beat and the result beat.
// ----------------------------------------------------------------------------
interface lwh_in_if
    import lwh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                mode;
    logic                noise_up;
    logic [BIN_BITS-1:0] read_bin;

    modport source (output valid, output mode, output noise_up, output read_bin,
                    input ready);
    modport sink   (input valid, input mode, input noise_up, input read_bin,
                    output ready);
endinterface

interface lwh_out_if
    import lwh_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [POS_BITS-1:0] position;
    logic [BIN_BITS-1:0]        bin_hit;
    logic                       counted;
    logic                       saturated;
    logic [COUNT_BITS-1:0]      bin_count;

    modport source (output valid, output position, output bin_hit, output counted,
                    output saturated, output bin_count, input ready);
    modport sink   (input valid, input position, input bin_hit, input counted,
                    input saturated, input bin_count, output ready);
endinterface
`default_nettype wire

FILE: src/langevin_walk_histogram_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Walk step: an accepted beat goes through MUL, ADD, the bit-serial bin divider
// (one quotient bit per step), BIN, RD, INC and DONE, where its result enters
// the output register once that is free; only then is the next beat taken.
// Bin read: MUL, RD, INC, DONE. A pending result does not block acceptance of
// the next beat. Reset (synchronous, active low) is followed by a clearing pass
// over every histogram entry; no beat is accepted until it ends.
// ----------------------------------------------------------------------------
// Langevin walk histogram top level
// Fixed-point decaying random walk whose positions are binned into counters.
// ----------------------------------------------------------------------------
module langevin_walk_histogram_top
    import lwh_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    lwh_in_if.sink                        i_item,
    lwh_out_if.source                     o_result
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    lwh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lwh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_mode      (i_item.mode),
        .i_noise_up  (i_item.noise_up),
        .i_read_bin  (i_item.read_bin),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_position  (o_result.position),
        .o_bin_hit   (o_result.bin_hit),
        .o_counted   (o_result.counted),
        .o_saturated (o_result.saturated),
        .o_bin_count (o_result.bin_count)
    );

    assign i_item.ready = w_in_ready;

endmodule
`default_nettype wire

FILE: src/lwh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Langevin walk histogram controller
// Sequences the clearing pass and each beat through the datapath.
// ----------------------------------------------------------------------------
module lwh_ctrl
    import lwh_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_stat.is_read ? S_RD : S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_BIN;
                end
            end
            S_BIN: begin
                o_cmd.bin = 1'b1;
                n_state   = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_INC;
            end
            S_INC: begin
                o_cmd.inc = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/lwh_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Langevin walk histogram datapath
// Registers, decay multiplier, serial divider, histogram memory and output.
// ----------------------------------------------------------------------------
module lwh_dp
    import lwh_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0]   i_cfg_data,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_stat                        o_stat,
    input  wire logic                       i_mode,
    input  wire logic                       i_noise_up,
    input  wire logic [BIN_BITS-1:0]        i_read_bin,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic signed [POS_BITS-1:0]      o_position,
    output logic [BIN_BITS-1:0]             o_bin_hit,
    output logic                            o_counted,
    output logic                            o_saturated,
    output logic [COUNT_BITS-1:0]           o_bin_count
);

    // Configuration registers.
    logic [COEF_BITS-1:0]       r_decay;
    logic [COEF_BITS-1:0]       r_noise;
    logic [COEF_BITS-1:0]       r_top;
    logic [COEF_BITS-1:0]       r_width;
    logic [USED_BITS-1:0]       r_used;
    logic signed [POS_BITS-1:0] r_start_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay     <= DECAY_RESET;
            r_noise     <= NOISE_RESET;
            r_top       <= TOP_RESET;
            r_width     <= WIDTH_RESET;
            r_used      <= USED_RESET;
            r_start_pos <= START_POS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DECAY:     r_decay     <= i_cfg_data[COEF_BITS-1:0];
                CFG_NOISE:     r_noise     <= i_cfg_data[COEF_BITS-1:0];
                CFG_TOP:       r_top       <= i_cfg_data[COEF_BITS-1:0];
                CFG_WIDTH:     r_width     <= i_cfg_data[COEF_BITS-1:0];
                CFG_USED:      r_used      <= i_cfg_data[USED_BITS-1:0];
                CFG_START_POS: r_start_pos <= $signed(i_cfg_data[POS_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // Latched input beat.
    logic                r_mode;
    logic                r_up;
    logic [BIN_BITS-1:0] r_rbin;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_up   <= i_noise_up;
            r_rbin <= i_read_bin;
        end
    end

    // Clearing pass index.
    logic [BIN_BITS-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Position update: multiply, then round half up, add noise and clamp.
    logic signed [POS_BITS-1:0]   r_walk_pos;
    logic signed [2*POS_BITS-1:0] w_prod;
    logic signed [2*POS_BITS-2:0] r_prod;
    logic signed [2*POS_BITS-2:0] w_round;
    logic signed [POS_BITS-1:0]   w_scaled;
    logic signed [POS_BITS+1:0]   w_sum;
    logic signed [POS_BITS-1:0]   w_next;
    logic                         w_sat;
    logic signed [POS_BITS+1:0]   w_diff;
    logic                         r_sat;
    logic                         r_above;

    assign w_prod   = r_walk_pos * $signed({1'b0, r_decay});
    assign w_round  = r_prod + $signed({{POS_BITS{1'b0}}, 1'b1, 15'd0});
    assign w_scaled = w_round[2*POS_BITS-2:COEF_BITS];

    always_comb begin
        if (r_up) begin
            w_sum = {{2{w_scaled[POS_BITS-1]}}, w_scaled} + $signed({3'b000, r_noise});
        end else begin
            w_sum = {{2{w_scaled[POS_BITS-1]}}, w_scaled} - $signed({3'b000, r_noise});
        end
        priority if (w_sum > POS_MAX) begin
            w_next = POS_MAX[POS_BITS-1:0];
            w_sat  = 1'b1;
        end else if (w_sum < POS_MIN) begin
            w_next = POS_MIN[POS_BITS-1:0];
            w_sat  = 1'b1;
        end else begin
            w_next = w_sum[POS_BITS-1:0];
            w_sat  = 1'b0;
        end
        // Distance below the top edge; negative means above it.
        w_diff = $signed({3'b000, r_top}) - {{2{w_next[POS_BITS-1]}}, w_next};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_prod[2*POS_BITS-2:0];
        end
        if (i_cmd.add) begin
            r_sat   <= w_sat;
            r_above <= w_diff[POS_BITS+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_pos <= START_POS_RESET;
        end else if (i_cmd.clr_step && r_clr_idx == '0) begin
            r_walk_pos <= r_start_pos;
        end else if (i_cmd.add) begin
            r_walk_pos <= w_next;
        end
    end

    // Restoring divider: distance / bin_width, one quotient bit per cycle.
    logic [POS_BITS-1:0]     r_quo;
    logic [COEF_BITS-1:0]    r_rem;
    logic [DIV_CNT_BITS-1:0] r_div_cnt;
    logic [POS_BITS-1:0]     w_trial;
    logic [POS_BITS:0]       w_sub;

    assign w_trial = {r_rem, r_quo[POS_BITS-1]};
    assign w_sub   = {1'b0, w_trial} - {2'b00, r_width};

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_quo     <= w_diff[POS_BITS-1:0];
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            if (!w_sub[POS_BITS]) begin
                r_rem <= w_sub[COEF_BITS-1:0];
                r_quo <= {r_quo[POS_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[COEF_BITS-1:0];
                r_quo <= {r_quo[POS_BITS-2:0], 1'b0};
            end
        end
    end

    // Bin decision.
    logic [USED_BITS-1:0] w_used;
    logic [POS_BITS:0]    w_k;
    logic                 w_hit;
    logic                 r_hit;
    logic [BIN_BITS-1:0]  r_bin;

    assign w_used = (r_used > USED_BITS'(MAX_BINS)) ? USED_BITS'(MAX_BINS) : r_used;
    assign w_k    = r_above ? '0 : ({1'b0, r_quo} + 1'b1);
    assign w_hit  = (r_above || r_width != '0)
                    && (w_k < {{(POS_BITS+1-USED_BITS){1'b0}}, w_used});

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin) begin
            r_hit <= w_hit;
            r_bin <= w_hit ? w_k[BIN_BITS-1:0] : '0;
        end
    end

    // Histogram memory with registered read.
    logic [COUNT_BITS-1:0] mem_hist [MAX_BINS];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [COUNT_BITS-1:0] w_inc;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  w_we;
    logic [BIN_BITS-1:0]   w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;
    logic [BIN_BITS-1:0]   w_raddr;

    assign w_inc   = (r_rdata == '1) ? r_rdata : r_rdata + 1'b1;
    assign w_we    = i_cmd.clr_step || (i_cmd.inc && !r_mode && r_hit);
    assign w_waddr = i_cmd.clr_step ? r_clr_idx : r_bin;
    assign w_wdata = i_cmd.clr_step ? '0 : w_inc;
    assign w_raddr = r_mode ? r_rbin : r_bin;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_hist[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem_hist[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.inc) begin
            priority if (r_mode) begin
                r_cnt <= r_rdata;
            end else if (r_hit) begin
                r_cnt <= w_inc;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Output register.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_position  <= r_walk_pos;
            o_bin_hit   <= r_mode ? '0 : r_bin;
            o_counted   <= !r_mode && r_hit;
            o_saturated <= !r_mode && r_sat;
            o_bin_count <= r_cnt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.is_read  = r_mode;
    assign o_stat.div_last = (r_div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1));
    assign o_stat.clr_last = (r_clr_idx == '1);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

`ifndef SYNTHESIS
    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.inc && !r_mode && r_hit) |-> ({1'b0, r_bin} < w_used))
        else $error("counted bin lies outside the bins in use");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && !r_mode && r_sat)
        |=> (o_position == POS_MAX[POS_BITS-1:0] || o_position == POS_MIN[POS_BITS-1:0]))
        else $error("clamped position is not at a range limit");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.inc && !r_mode && r_hit) |=> (r_cnt != '0))
        else $error("counted bin reports a zero count");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/lwh_walk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Langevin walk histogram checker
// Tracks register writes and accepted input beats, predicts every result
// beat from a private copy of the walk position and the bin counters, and
// compares each accepted result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module lwh_walk_checker
    import lwh_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    lwh_in_if                        i_item,
    lwh_out_if                       i_result,
    output int                       o_mismatches,
    output int                       o_pending
);

    typedef struct {
        logic signed [POS_BITS-1:0] position;
        logic [BIN_BITS-1:0]        bin_hit;
        logic                       counted;
        logic                       saturated;
        logic [COUNT_BITS-1:0]      bin_count;
    } walk_beat_t;

    logic [COEF_BITS-1:0]        decay_q;
    logic [COEF_BITS-1:0]        noise_q;
    logic [COEF_BITS-1:0]        top_q;
    logic [COEF_BITS-1:0]        width_q;
    logic [USED_BITS-1:0]        used_q;
    logic signed [POS_BITS-1:0]  start_q;
    logic signed [POS_BITS-1:0]  walk_pos;
    logic [COUNT_BITS-1:0]       bin_counts [MAX_BINS];
    walk_beat_t                  expected_beats [$];
    int                          reports;

    // Applies one input beat to the walk and histogram and forms its result.
    task automatic take_beat(input logic is_read, input logic up,
                             input logic [BIN_BITS-1:0] rbin, output walk_beat_t beat);
        longint nxt;
        longint used;
        longint k;
        logic   hit;
        logic   sat;
        beat.position  = walk_pos;
        beat.bin_hit   = '0;
        beat.counted   = 1'b0;
        beat.saturated = 1'b0;
        beat.bin_count = '0;
        if (is_read) begin
            beat.bin_count = bin_counts[rbin];
        end else begin
            // Decay with round half up, then the noise kick, then clamp.
            nxt = (longint'(walk_pos) * longint'(decay_q) + 64'sd32768) >>> 16;
            nxt = up ? nxt + longint'(noise_q) : nxt - longint'(noise_q);
            sat = 1'b0;
            if (nxt > longint'(POS_MAX)) begin
                nxt = longint'(POS_MAX);
                sat = 1'b1;
            end
            if (nxt < longint'(POS_MIN)) begin
                nxt = longint'(POS_MIN);
                sat = 1'b1;
            end
            walk_pos = nxt[POS_BITS-1:0];
            beat.position  = walk_pos;
            beat.saturated = sat;

            used = (used_q > MAX_BINS) ? MAX_BINS : used_q;
            hit = 1'b0;
            k = 0;
            if (nxt > longint'(top_q)) begin
                hit = 1'b1;
            end else if (width_q != 0) begin
                k = (longint'(top_q) - nxt) / longint'(width_q) + 1;
                hit = 1'b1;
            end
            if (hit && k >= used) begin
                hit = 1'b0;
            end
            if (hit) begin
                if (bin_counts[k] != '1) begin
                    bin_counts[k] = bin_counts[k] + 1'b1;
                end
                beat.bin_hit   = k[BIN_BITS-1:0];
                beat.counted   = 1'b1;
                beat.bin_count = bin_counts[k];
            end
        end
    endtask

    always @(posedge i_clk) begin : track_beats
        walk_beat_t want;
        if (!i_rst_n) begin
            decay_q  = DECAY_RESET;
            noise_q  = NOISE_RESET;
            top_q    = TOP_RESET;
            width_q  = WIDTH_RESET;
            used_q   = USED_RESET;
            start_q  = START_POS_RESET;
            walk_pos = START_POS_RESET;
            for (int i = 0; i < MAX_BINS; i++) begin
                bin_counts[i] = '0;
            end
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DECAY:     decay_q = i_cfg_data[COEF_BITS-1:0];
                    CFG_NOISE:     noise_q = i_cfg_data[COEF_BITS-1:0];
                    CFG_TOP:       top_q   = i_cfg_data[COEF_BITS-1:0];
                    CFG_WIDTH:     width_q = i_cfg_data[COEF_BITS-1:0];
                    CFG_USED:      used_q  = i_cfg_data[USED_BITS-1:0];
                    // The start position is only loaded by a reset.
                    CFG_START_POS: start_q = i_cfg_data[POS_BITS-1:0];
                    default: ;
                endcase
            end

            // Compare before predicting: a beat accepted at this edge cannot
            // have its result leave at the same edge.
            if (i_result.valid && i_result.ready) begin
                if (expected_beats.size() == 0) begin
                    o_mismatches++;
                    if (reports < 10) begin
                        reports++;
                        $display("[%0t] result beat with nothing expected: pos %0d bin %0d",
                                 $time, i_result.position, i_result.bin_hit,
                                 " counted %0b sat %0b count %0d", i_result.counted,
                                 i_result.saturated, i_result.bin_count);
                    end
                end else begin
                    want = expected_beats.pop_front();
                    if (i_result.position !== want.position
                            || i_result.bin_hit !== want.bin_hit
                            || i_result.counted !== want.counted
                            || i_result.saturated !== want.saturated
                            || i_result.bin_count !== want.bin_count) begin
                        o_mismatches++;
                        if (reports < 10) begin
                            reports++;
                            $display("[%0t] result mismatch: expected pos %0d bin %0d",
                                     $time, want.position, want.bin_hit,
                                     " counted %0b sat %0b count %0d", want.counted,
                                     want.saturated, want.bin_count);
                            $display("[%0t]                  actual   pos %0d bin %0d",
                                     $time, i_result.position, i_result.bin_hit,
                                     " counted %0b sat %0b count %0d", i_result.counted,
                                     i_result.saturated, i_result.bin_count);
                        end
                    end
                end
            end

            if (i_item.valid && i_item.ready) begin
                take_beat(i_item.mode, i_item.noise_up, i_item.read_bin, want);
                expected_beats.push_back(want);
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

FILE: tb/sv/langevin_walk_histogram_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Langevin walk histogram testbench
// Drives walk steps and bin reads through a series of register settings,
// with random gaps on the input side and random stalls on the result side,
// and leaves all checking to the walk checker beside the block.
// ----------------------------------------------------------------------------
module langevin_walk_histogram_top_tb;
    import lwh_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 30;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 141;

    // Indexes with no register behind them.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [COEF_BITS-1:0] decay;
        logic [COEF_BITS-1:0] noise;
        logic [COEF_BITS-1:0] top;
        logic [COEF_BITS-1:0] width;
        logic [USED_BITS-1:0] used;
    } walk_cfg_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    int                       mismatches;
    int                       pending;
    bit                       quiet;
    bit                       hold_request;
    walk_cfg_t                cur_cfg;

    lwh_in_if  item_ch ();
    lwh_out_if result_ch ();

    langevin_walk_histogram_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    lwh_walk_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("langevin_walk_histogram_top_tb: FAIL");
        $finish;
    end

    // Mostly no idle cycles, often a few, now and then a long stretch.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic walk_cfg_t make_cfg(input logic [COEF_BITS-1:0] decay,
                                           input logic [COEF_BITS-1:0] noise,
                                           input logic [COEF_BITS-1:0] top,
                                           input logic [COEF_BITS-1:0] width,
                                           input logic [USED_BITS-1:0] used);
        walk_cfg_t c;
        c.decay = decay;
        c.noise = noise;
        c.top   = top;
        c.width = width;
        c.used  = used;
        return c;
    endfunction

    function automatic walk_cfg_t random_cfg();
        walk_cfg_t c;
        int        r;
        r = $urandom_range(0, 9);
        c.decay = (r == 0) ? '0 : (r == 1) ? '1 :
                  (r < 7) ? COEF_BITS'($urandom_range(60000, 65535)) : COEF_BITS'($urandom);
        r = $urandom_range(0, 9);
        c.noise = (r == 0) ? '0 : (r == 1) ? '1 :
                  (r < 7) ? COEF_BITS'($urandom_range(1, 4095)) : COEF_BITS'($urandom);
        r = $urandom_range(0, 9);
        c.top   = (r == 0) ? '0 : (r == 1) ? '1 : COEF_BITS'($urandom);
        r = $urandom_range(0, 9);
        c.width = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? COEF_BITS'(1) :
                  COEF_BITS'($urandom_range(1, 512));
        r = $urandom_range(0, 9);
        c.used  = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? USED_BITS'(MAX_BINS) :
                  USED_BITS'($urandom_range(1, MAX_BINS));
        return c;
    endfunction

    // Half the reads go near the bin that a walk resting at zero would hit.
    function automatic logic [BIN_BITS-1:0] pick_bin();
        int centre;
        int v;
        if ($urandom_range(0, 1)) begin
            return BIN_BITS'($urandom_range(0, MAX_BINS - 1));
        end
        centre = (cur_cfg.width == 0) ? 0 : int'(cur_cfg.top) / int'(cur_cfg.width) + 1;
        v = centre + int'($urandom_range(0, 80)) - 40;
        if (v < 0) begin
            v = 0;
        end
        if (v > MAX_BINS - 1) begin
            v = MAX_BINS - 1;
        end
        return BIN_BITS'(v);
    endfunction

    task automatic send_item(input logic is_read, input logic up,
                             input logic [BIN_BITS-1:0] rbin);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_ch.valid    <= 1'b1;
        item_ch.mode     <= is_read;
        item_ch.noise_up <= up;
        item_ch.read_bin <= rbin;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    // Stops offering beats and waits until every result beat has been taken.
    task automatic drain();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Leaves the write enable high; program_walk lowers it after its last write.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic program_walk(input walk_cfg_t c);
        write_reg(CFG_DECAY, CFG_DATA_BITS'(c.decay));
        write_reg(CFG_NOISE, CFG_DATA_BITS'(c.noise));
        write_reg(CFG_TOP,   CFG_DATA_BITS'(c.top));
        write_reg(CFG_WIDTH, CFG_DATA_BITS'(c.width));
        write_reg(CFG_USED,  CFG_DATA_BITS'(c.used));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    // The receiver stalls at random, and holds off for a long stretch when asked.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else begin
                stall_left = quiet ? 0 : idle_len();
                if (stall_left > 0) begin
                    stall_left--;
                    result_ch.ready <= 1'b0;
                end else begin
                    result_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        walk_cfg_t defaults;
        walk_cfg_t c;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        item_ch.valid    <= 1'b0;
        item_ch.mode     <= 1'b0;
        item_ch.noise_up <= 1'b0;
        item_ch.read_bin <= '0;
        quiet = 1'b1;
        defaults = make_cfg(DECAY_RESET, NOISE_RESET, TOP_RESET, WIDTH_RESET, USED_RESET);
        cur_cfg = defaults;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Wait for the clearing pass to end before touching the registers.
        @(negedge i_clk);
        while (!item_ch.ready) @(negedge i_clk);

        // The start position only matters at a reset, and the spare indexes
        // must not disturb any register.
        write_reg(CFG_START_POS, {1'b1, 16'h0000});
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        program_walk(defaults);
        send_item(1'b1, 1'b0, '0);
        send_item(1'b1, 1'b1, '1);
        send_item(1'b0, 1'b1, '0);
        send_item(1'b0, 1'b1, '1);
        send_item(1'b0, 1'b0, '0);
        send_item(1'b0, 1'b1, '0);
        send_item(1'b1, 1'b0, 10'd400);
        drain();

        // No decay and a full-scale kick: above the top edge, then below the bins in use.
        program_walk(make_cfg('0, '1, TOP_RESET, WIDTH_RESET, USED_RESET));
        send_item(1'b0, 1'b1, '0);
        send_item(1'b0, 1'b0, '0);
        send_item(1'b1, 1'b0, '0);
        drain();

        // Full decay and full kick clamp at both ends of the range.
        program_walk(make_cfg('1, '1, TOP_RESET, WIDTH_RESET, USED_RESET));
        send_item(1'b0, 1'b0, '0);
        send_item(1'b0, 1'b1, '0);
        send_item(1'b0, 1'b1, '0);
        send_item(1'b0, 1'b1, '0);
        drain();

        // Zero bin width counts only positions above the top edge.
        program_walk(make_cfg('0, 16'd100, '0, '0, USED_RESET));
        send_item(1'b0, 1'b1, '0);
        send_item(1'b0, 1'b0, '0);
        drain();

        // More bins than exist: bin 936 is counted, bin 1500 is not.
        program_walk(make_cfg('0, 16'd64600, '1, 16'd1, '1));
        send_item(1'b0, 1'b1, '0);
        send_item(1'b1, 1'b0, 10'd936);
        drain();
        program_walk(make_cfg('0, 16'd64036, '1, 16'd1, '1));
        send_item(1'b0, 1'b1, '0);
        drain();

        // No bins in use.
        program_walk(make_cfg('0, 16'd64600, '1, 16'd1, '0));
        send_item(1'b0, 1'b1, '0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       c = defaults;
                1:       c = make_cfg('1, 16'd300, 16'd32768, 16'd64, USED_BITS'(MAX_BINS));
                2:       c = make_cfg('1, '1, '1, '1, '1);
                3:       c = defaults;
                default: c = random_cfg();
            endcase
            program_walk(c);
            quiet = (p % 3 == 1);
            if (p == 3) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_item(1'b1, 1'($urandom_range(0, 1)), pick_bin());
                end else begin
                    send_item(1'b0, 1'($urandom_range(0, 1)), BIN_BITS'($urandom));
                end
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("langevin_walk_histogram_top_tb: PASS");
        end else begin
            $display("langevin_walk_histogram_top_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
src/lwh_pkg.sv
src/lwh_if.sv
src/lwh_ctrl.sv
src/lwh_dp.sv
src/langevin_walk_histogram_top.sv
tb/sv/lwh_walk_checker.sv
tb/sv/langevin_walk_histogram_top_tb.sv
